/* rtl/lmag_pkg.sv */
// Package for the loudness match auto gain block: widths, constants and shared types.
package lmag_pkg;

    localparam int SampleWidth = 24;
    localparam int CoefWidth   = 24;
    localparam int PowerWidth  = 48;
    localparam int GainWidth   = 32;
    localparam int OutWidth    = 16;
    localparam int NumRegs     = 8;
    localparam int IdxWidth    = 3;

    localparam logic [PowerWidth-1:0] PwrInit    = 48'd7036;
    localparam logic [PowerWidth-1:0] PwrSilence = 48'd703687;
    localparam logic [PowerWidth-1:0] PwrEps     = 48'd703;
    localparam logic [GainWidth-1:0]  GainOne    = 32'd1073741824;
    localparam logic [GainWidth-1:0]  GainMin    = 32'd269711752;
    localparam logic [GainWidth-1:0]  GainMax    = 32'd4274643195;
    localparam logic [GainWidth-1:0]  DampQ      = 32'd343597384;
    localparam logic [16:0]           MixMid     = 17'd56361;
    localparam logic [16:0]           MixRaw     = 17'd9175;

    localparam logic [IdxWidth-1:0] RegHp     = 3'd0;
    localparam logic [IdxWidth-1:0] RegLp     = 3'd1;
    localparam logic [IdxWidth-1:0] RegFast   = 3'd2;
    localparam logic [IdxWidth-1:0] RegSlow   = 3'd3;
    localparam logic [IdxWidth-1:0] RegTarget = 3'd4;
    localparam logic [IdxWidth-1:0] RegFall   = 3'd5;
    localparam logic [IdxWidth-1:0] RegRise   = 3'd6;
    localparam logic [IdxWidth-1:0] RegBypass = 3'd7;

    localparam logic [CoefWidth-1:0] PoleReset [NumRegs] = '{
        24'd16613316, 24'd7165600, 24'd16769449, 24'd16776488,
        24'd16776678, 24'd16775627, 24'd16776805, 24'd16774304
    };

    // One queued frame.
    typedef struct packed {
        logic signed [SampleWidth-1:0] dry_l;
        logic signed [SampleWidth-1:0] dry_r;
        logic signed [SampleWidth-1:0] wet_l;
        logic signed [SampleWidth-1:0] wet_r;
        logic                          en;
        logic                          st;
    } t_frame;

    typedef logic [CoefWidth-1:0] t_poles [NumRegs];

endpackage

/* rtl/lmag_front.sv */
// Front end: frame acceptance and a two-entry frame queue.
module lmag_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  lmag_pkg::t_frame       i_frame,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lmag_pkg::t_frame       o_frame
);
    lmag_pkg::t_frame r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_frame = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_q[r_wp] <= i_frame;
    end
endmodule

/* rtl/lmag_div.sv */
// Sequential unit: floor(sqrt(floor(n*2^60/d))) saturated, as Q2.30.
module lmag_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lmag_pkg::PowerWidth-1:0]  i_num,
    input  logic [lmag_pkg::PowerWidth-1:0]  i_den,
    output logic                             o_done,
    output logic [lmag_pkg::GainWidth-1:0]   o_root
);
    localparam int PW = lmag_pkg::PowerWidth;
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT} t_state;

    t_state       r_state;
    logic [PW:0]  r_rem;
    logic [PW-1:0] r_den;
    logic [63:0]  r_q;
    logic [63:0]  r_sq;
    logic [33:0]  r_res;
    logic [65:0]  r_srem;
    logic [5:0]   r_cnt;
    logic         r_sat;
    logic [PW:0]  w_rem2;
    logic [65:0]  w_trial;
    logic [65:0]  w_sr;

    // Low four numerator bits, held stable by the caller during a run.
    function automatic logic i_num_bit(input logic [5:0] k);
        logic [1:0] j;
        j = 2'd3 - k[1:0];
        return i_num[j];
    endfunction

    // Division: quotient bits of n/d shifted by 60; 4 integer + 60 fraction bits.
    assign w_rem2  = {r_rem[PW-1:0], 1'b0};
    // Sqrt: two bits a step.
    assign w_sr    = {r_srem[63:0], r_sq[63:62]};
    assign w_trial = {r_res, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sat   <= ({4'd0, i_num} >= {i_den, 4'd0});
                        r_den   <= i_den;
                        r_rem   <= {1'b0, i_num >> 4};
                        r_q     <= '0;
                        r_cnt   <= 6'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Quotient of (n >> 4) bits first, stepping numerator bits in.
                    begin
                        logic [PW:0] v;
                        v = (r_cnt < 6'd4) ? {r_rem[PW-1:0], i_num_bit(r_cnt)} : w_rem2;
                        if (v >= {1'b0, r_den}) begin
                            r_rem <= v - {1'b0, r_den};
                            r_q   <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= v;
                            r_q   <= {r_q[62:0], 1'b0};
                        end
                    end
                    if (r_cnt == 6'd63) begin
                        r_state <= S_SQRT;
                        r_cnt   <= 6'd0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 6'd0) begin
                        r_sq   <= r_q;
                        r_res  <= '0;
                        r_srem <= '0;
                        r_cnt  <= 6'd1;
                    end else begin
                        if (w_sr >= w_trial) begin
                            r_srem <= w_sr - w_trial;
                            r_res  <= {r_res[32:0], 1'b1};
                        end else begin
                            r_srem <= w_sr;
                            r_res  <= {r_res[32:0], 1'b0};
                        end
                        r_sq <= {r_sq[61:0], 2'b00};
                        if (r_cnt == 6'd32) begin
                            r_state <= S_IDLE;
                            o_done  <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_root = r_sat ? {lmag_pkg::GainWidth{1'b1}} : r_res[31:0];
endmodule

/* rtl/lmag_back.sv */
// Back end: weighting filters, power followers and gain control sequencer.
module lmag_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lmag_pkg::t_poles                i_poles,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  lmag_pkg::t_frame                i_frame,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lmag_pkg::OutWidth-1:0]   o_gain
);
    localparam int PW = lmag_pkg::PowerWidth;
    localparam int GW = lmag_pkg::GainWidth;
    localparam int CW = lmag_pkg::CoefWidth;

    typedef enum logic [4:0] {
        S_IDLE, S_HP, S_LP, S_MIX, S_SQ, S_NEXT, S_AVG,
        S_F0, S_F1, S_FSUM, S_CHK, S_D0, S_D1, S_D2, S_DW,
        S_CREST, S_DAMP, S_MIXG, S_TG0, S_TG1, S_CG0, S_CG1, S_CGS, S_OUT
    } t_state;

    t_state r_state;
    logic signed [31:0] r_flt [8];
    logic [1:0]  r_ch;          // 0 dry l, 1 wet l, 2 dry r, 3 wet r
    logic signed [24:0] r_x;
    logic signed [31:0] r_lo, r_m;
    logic [PW-1:0] r_sq [4];
    logic [PW-1:0] r_dp, r_wp;
    logic [PW-1:0] r_dfp, r_wfp, r_dsp, r_wsp;
    logic [1:0]  r_fi;
    logic [PW+1:0] r_acc;
    logic [GW-1:0] r_tg, r_cg, r_m0, r_dc, r_wc;
    logic [1:0]  r_di;
    logic        r_dstart;
    logic [GW-1:0] r_f;
    logic [lmag_pkg::OutWidth-1:0] r_out;

    lmag_pkg::t_frame r_fr;
    logic        w_ddone;
    logic [GW-1:0] w_root;
    logic [PW-1:0] r_num, r_den;

    lmag_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_ddone), .o_root(w_root)
    );

    // Rounded arithmetic shift right by 24 of a 64-bit signed value.
    function automatic logic signed [31:0] rnd24(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd8388608) >>> 24;
        return t[31:0];
    endfunction

    // floor(p*a/2^24) split as in the follower definition.
    function automatic logic [63:0] mulf(input logic [63:0] p, input logic [CW-1:0] a);
        logic [63:0] hi, lo;
        hi = (p >> 24) * {40'd0, a};
        lo = (({40'd0, p[23:0]}) * {40'd0, a}) >> 24;
        return hi + lo;
    endfunction

    function automatic logic [GW-1:0] clampg(input logic [63:0] g);
        if (g < {32'd0, lmag_pkg::GainMin}) return lmag_pkg::GainMin;
        if (g > {32'd0, lmag_pkg::GainMax}) return lmag_pkg::GainMax;
        return g[31:0];
    endfunction

    logic [2:0] w_fidx;
    logic signed [23:0] w_samp;
    logic [CW:0] w_onem;
    always_comb begin
        w_fidx = {r_ch[1], r_ch[0], 1'b0};
        case (r_ch)
            2'd0: w_samp = r_fr.dry_l;
            2'd1: w_samp = r_fr.wet_l;
            2'd2: w_samp = r_fr.dry_r;
            2'd3: w_samp = r_fr.wet_r;
            default: w_samp = r_fr.dry_l;
        endcase
        w_onem = 25'h1000000;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_gain  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
            for (int k = 0; k < 8; k++) r_flt[k] <= '0;
            r_dfp <= lmag_pkg::PwrInit;
            r_wfp <= lmag_pkg::PwrInit;
            r_dsp <= lmag_pkg::PwrInit;
            r_wsp <= lmag_pkg::PwrInit;
            r_tg  <= lmag_pkg::GainOne;
            r_cg  <= lmag_pkg::GainOne;
        end else begin
            r_dstart <= 1'b0;
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_fr    <= i_frame;
                    r_ch    <= 2'd0;
                    r_state <= S_HP;
                end
                S_HP: begin
                    logic signed [31:0] lo;
                    r_x <= {w_samp[23], w_samp};
                    lo = rnd24($signed({1'b0, i_poles[lmag_pkg::RegHp]}) * 64'(r_flt[w_fidx])
                        + $signed({1'b0, w_onem - {1'b0, i_poles[lmag_pkg::RegHp]}})
                          * 64'(w_samp));
                    r_flt[w_fidx] <= lo;
                    r_lo    <= lo;
                    r_state <= S_LP;
                end
                S_LP: begin
                    logic signed [31:0] m;
                    m = rnd24($signed({1'b0, i_poles[lmag_pkg::RegLp]})
                              * 64'(r_flt[w_fidx + 3'd1])
                        + $signed({1'b0, w_onem - {1'b0, i_poles[lmag_pkg::RegLp]}})
                          * (64'(r_x) - 64'(r_lo)));
                    r_flt[w_fidx + 3'd1] <= m;
                    r_m     <= m;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    logic signed [63:0] w;
                    w = ($signed({1'b0, lmag_pkg::MixMid}) * 64'(r_m)
                        + $signed({1'b0, lmag_pkg::MixRaw}) * 64'(r_x) + 64'sd32768) >>> 16;
                    r_lo    <= w[31:0];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    logic [31:0] a;
                    logic [63:0] s;
                    a = r_lo[31] ? 32'(-r_lo) : 32'(r_lo);
                    s = {32'd0, a} * {32'd0, a};
                    r_sq[r_ch] <= s[PW-1:0];
                    r_state    <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_ch == 2'd0 || (r_ch == 2'd2 && r_fr.st)) begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_HP;
                    end else if (r_ch == 2'd1 && r_fr.st) begin
                        r_ch    <= 2'd2;
                        r_state <= S_HP;
                    end else begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (r_fr.st) begin
                        r_dp <= PW'(({1'b0, r_sq[0]} + {1'b0, r_sq[2]}) >> 1);
                        r_wp <= PW'(({1'b0, r_sq[1]} + {1'b0, r_sq[3]}) >> 1);
                    end else begin
                        r_dp <= r_sq[0];
                        r_wp <= r_sq[1];
                    end
                    r_fi    <= 2'd0;
                    r_state <= S_F0;
                end
                S_F0: begin
                    logic [PW-1:0] p, x;
                    logic [CW-1:0] a;
                    case (r_fi)
                        2'd0: begin p = r_dfp; x = r_dp; a = i_poles[lmag_pkg::RegFast]; end
                        2'd1: begin p = r_wfp; x = r_wp; a = i_poles[lmag_pkg::RegFast]; end
                        2'd2: begin p = r_dsp; x = r_dp; a = i_poles[lmag_pkg::RegSlow]; end
                        default: begin p = r_wsp; x = r_wp; a = i_poles[lmag_pkg::RegSlow]; end
                    endcase
                    r_acc   <= (PW+2)'(mulf(64'(p), a));
                    r_num   <= x;
                    r_den   <= PW'(w_onem - {1'b0, a});
                    r_state <= S_F1;
                end
                S_F1: begin
                    logic [63:0] t;
                    logic [PW-1:0] r;
                    t = 64'(r_acc) + mulf(64'(r_num), r_den[CW-1:0] | {CW{r_den[CW]}});
                    if (r_den[CW]) t = 64'(r_acc) + 64'(r_num);
                    r = (t > 64'({PW{1'b1}})) ? {PW{1'b1}} : t[PW-1:0];
                    case (r_fi)
                        2'd0: r_dfp <= r;
                        2'd1: r_wfp <= r;
                        2'd2: r_dsp <= r;
                        default: r_wsp <= r;
                    endcase
                    r_fi    <= r_fi + 2'd1;
                    r_state <= (r_fi == 2'd3) ? S_CHK : S_F0;
                end
                S_CHK: begin
                    if (!r_fr.en) begin
                        r_tg    <= lmag_pkg::GainOne;
                        r_state <= S_CG0;
                    end else if (r_dsp > lmag_pkg::PwrSilence && r_wsp > lmag_pkg::PwrEps) begin
                        r_di    <= 2'd0;
                        r_state <= S_D0;
                    end else begin
                        r_state <= S_CG0;
                    end
                end
                S_D0: begin
                    case (r_di)
                        2'd0: begin r_num <= r_dsp + lmag_pkg::PwrEps;
                                    r_den <= r_wsp + lmag_pkg::PwrEps; end
                        2'd1: begin r_num <= r_dfp + lmag_pkg::PwrEps;
                                    r_den <= r_dsp + lmag_pkg::PwrEps; end
                        default: begin r_num <= r_wfp + lmag_pkg::PwrEps;
                                       r_den <= r_wsp + lmag_pkg::PwrEps; end
                    endcase
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_dstart <= 1'b1;
                    r_state  <= S_DW;
                end
                S_DW: if (w_ddone) begin
                    case (r_di)
                        2'd0: r_m0 <= clampg(64'(w_root));
                        2'd1: r_dc <= w_root;
                        default: r_wc <= w_root;
                    endcase
                    r_di    <= r_di + 2'd1;
                    r_state <= (r_di == 2'd2) ? S_CREST : S_D0;
                end
                S_CREST: begin
                    logic [GW:0] c, t;
                    c = (r_dc > r_wc) ? {1'b0, r_dc} : {1'b0, r_wc};
                    if (c > 33'd3221225472) c = 33'd3221225472;
                    t = (c > {1'b0, lmag_pkg::GainOne}) ? (c - {1'b0, lmag_pkg::GainOne}) >> 1
                                                        : '0;
                    r_f     <= t[GW-1:0];
                    r_state <= S_DAMP;
                end
                S_DAMP: begin
                    logic [63:0] p;
                    p = {32'd0, lmag_pkg::DampQ} * {32'd0, r_f};
                    r_f     <= lmag_pkg::GainOne - p[61:30];
                    r_state <= S_MIXG;
                end
                S_MIXG: begin
                    logic signed [33:0] d;
                    logic signed [66:0] p;
                    logic signed [66:0] rr;
                    d  = $signed({2'b00, r_m0}) - $signed({2'b00, lmag_pkg::GainOne});
                    p  = d * $signed({1'b0, r_f});
                    rr = (p + 67'sd536870912) >>> 30;
                    r_m0    <= 32'(rr + 67'sd1073741824);
                    r_state <= S_TG0;
                end
                S_TG0: begin
                    r_acc   <= (PW+2)'(mulf(64'(r_tg), i_poles[lmag_pkg::RegTarget]));
                    r_state <= S_TG1;
                end
                S_TG1: begin
                    logic [CW:0] om;
                    logic [63:0] t;
                    om = w_onem - {1'b0, i_poles[lmag_pkg::RegTarget]};
                    t  = om[CW] ? 64'(r_m0) : mulf(64'(r_m0), om[CW-1:0]);
                    r_tg    <= 32'(64'(r_acc) + t);
                    r_state <= S_CG0;
                end
                S_CG0: begin
                    logic [CW-1:0] a;
                    a = !r_fr.en ? i_poles[lmag_pkg::RegBypass]
                      : (r_tg < r_cg) ? i_poles[lmag_pkg::RegFall] : i_poles[lmag_pkg::RegRise];
                    r_acc   <= (PW+2)'(mulf(64'(r_cg), a));
                    r_den   <= PW'(w_onem - {1'b0, a});
                    r_state <= S_CG1;
                end
                S_CG1: begin
                    logic [63:0] t;
                    t = r_den[CW] ? 64'(r_tg) : mulf(64'(r_tg), r_den[CW-1:0]);
                    r_cg    <= clampg(64'(r_acc) + t);
                    r_state <= S_OUT;
                end
                S_OUT: if (!o_valid || i_ready) begin
                    r_out   <= 16'((({1'b0, r_cg} + 33'd32768) >> 16));
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/loudness_match_auto_gain_top.sv */
// Top level of the loudness match auto gain block: config registers, front, back.
// A mono frame takes fewer back-end filter passes than a stereo one. When enabled, with the
// dry slow power above silence and the wet slow power above the floor, gain control runs three
// serial divide and square-root runs (64 divide steps, then the root steps) in the back end's
// shared unit. The back end takes a new frame only when idle; the front queue holds two meanwhile.
// Reset (synchronous, active low) restores pole defaults, zero filters, unity gains.
module loudness_match_auto_gain_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lmag_pkg::IdxWidth-1:0]        i_cfg_idx,
    input  logic [lmag_pkg::CoefWidth-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [lmag_pkg::SampleWidth-1:0] i_dry_left,
    input  logic signed [lmag_pkg::SampleWidth-1:0] i_dry_right,
    input  logic signed [lmag_pkg::SampleWidth-1:0] i_wet_left,
    input  logic signed [lmag_pkg::SampleWidth-1:0] i_wet_right,
    input  logic                                 i_enabled,
    input  logic                                 i_stereo,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [lmag_pkg::OutWidth-1:0]        o_applied_gain
);
    lmag_pkg::t_poles r_poles;
    lmag_pkg::t_frame w_in, w_q;
    logic             w_qv, w_qr;

    // Pole registers; every index of the three-bit port names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lmag_pkg::NumRegs; k++) r_poles[k] <= lmag_pkg::PoleReset[k];
        end else if (i_cfg_we) begin
            r_poles[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign w_in = '{dry_l: i_dry_left, dry_r: i_dry_right, wet_l: i_wet_left,
                    wet_r: i_wet_right, en: i_enabled, st: i_stereo};

    lmag_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_frame(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_frame(w_q)
    );

    lmag_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_poles(r_poles), .i_valid(w_qv),
        .o_ready(w_qr), .i_frame(w_q), .o_valid(o_valid), .i_ready(i_ready),
        .o_gain(o_applied_gain)
    );

    // The output gain always lies between the two clamp limits.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_applied_gain >= 16'd4115 && o_applied_gain <= 16'd65226))
        else $error("applied gain outside clamp range");

    // A held result keeps its value while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_applied_gain))
        else $error("result changed while stalled");
endmodule
